/* rtl/utd_pkg.sv */
// shared widths, types and calendar tables for the utc date to epoch converter
`default_nettype none

package utd_pkg;

  // field widths
  localparam int YEAR_W  = 8;
  localparam int MON_W   = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int OUT_W   = 33;

  // day counts: years since 1970 fit in 17 bits, days before a month in 9
  localparam int YDAYS_W = 17;
  localparam int MDAYS_W = 9;

  // years counted from 1900
  localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(70);
  localparam logic [YEAR_W-1:0] YEAR_1900  = YEAR_W'(0);
  localparam logic [YEAR_W-1:0] YEAR_2100  = YEAR_W'(200);

  // leap years in 1900..1969, i.e. multiples of four in 1..69 as counted by (y-1)/4
  localparam logic [YDAYS_W-1:0] LEAPS_BEFORE_EPOCH = YDAYS_W'(17);
  localparam logic [YDAYS_W-1:0] DAYS_PER_YEAR      = YDAYS_W'(365);

  localparam logic [MON_W-1:0] MON_MARCH = MON_W'(2);

  // day count, hour, minute and second travelling between the two halves
  typedef struct packed {
    logic [OUT_W-1:0]  days;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } utd_days_t;

  // days in the months before the given one of a common year, saturating at 365 from index 12 up
  function automatic logic [MDAYS_W-1:0] month_days_before(input logic [MON_W-1:0] mon);
    logic [MDAYS_W-1:0] d;
    unique case (mon)
      4'd0:    d = MDAYS_W'(0);
      4'd1:    d = MDAYS_W'(31);
      4'd2:    d = MDAYS_W'(59);
      4'd3:    d = MDAYS_W'(90);
      4'd4:    d = MDAYS_W'(120);
      4'd5:    d = MDAYS_W'(151);
      4'd6:    d = MDAYS_W'(181);
      4'd7:    d = MDAYS_W'(212);
      4'd8:    d = MDAYS_W'(243);
      4'd9:    d = MDAYS_W'(273);
      4'd10:   d = MDAYS_W'(304);
      4'd11:   d = MDAYS_W'(334);
      default: d = MDAYS_W'(365);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/utd_day_count.sv */
// two pipeline stages that turn year, month and day into a day count since 1970
`default_nettype none

module utd_day_count (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [utd_pkg::YEAR_W-1:0] in_year,
  input  wire logic [utd_pkg::MON_W-1:0]  in_month,
  input  wire logic [utd_pkg::MDAY_W-1:0] in_mday,
  input  wire logic [utd_pkg::HOUR_W-1:0] in_hour,
  input  wire logic [utd_pkg::MIN_W-1:0]  in_minute,
  input  wire logic [utd_pkg::SEC_W-1:0]  in_second,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output utd_pkg::utd_days_t              dn_data
);
  import utd_pkg::*;

  // stage 1 registers
  logic                s1_v_r;
  logic [YDAYS_W-1:0]  s1_ydays_r;
  logic [MDAYS_W-1:0]  s1_mdays_r;
  logic [MDAY_W-1:0]   s1_mday_r;
  logic [HOUR_W-1:0]   s1_hour_r;
  logic [MIN_W-1:0]    s1_minute_r;
  logic [SEC_W-1:0]    s1_second_r;

  // stage 2 registers
  logic                s2_v_r;
  utd_days_t           s2_data_r;

  logic                s1_free;
  logic                s2_free;
  logic                leap;
  logic [YEAR_W-1:0]   year_m1;
  logic [YDAYS_W-1:0]  leaps;
  logic [YDAYS_W-1:0]  s1_ydays_nxt;
  logic [MDAYS_W-1:0]  s1_mdays_nxt;
  utd_days_t           s2_data_nxt;

  // a stage takes a new request when empty or when its content moves on
  assign s2_free  = !s2_v_r || dn_ready;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;

  // gregorian leap rule over 1900..2155: 1900 and 2100 are the only century misses
  assign leap = (in_year[1:0] == 2'b00) && (in_year != YEAR_1900) && (in_year != YEAR_2100);

  // whole years from 1970 up to the given year
  assign year_m1 = in_year - YEAR_W'(1);
  always_comb begin
    leaps = YDAYS_W'(year_m1 >> 2) - LEAPS_BEFORE_EPOCH;
    if (in_year > YEAR_2100) begin
      leaps = leaps - YDAYS_W'(1);
    end
    if (in_year > EPOCH_YEAR) begin
      s1_ydays_nxt = YDAYS_W'(in_year - EPOCH_YEAR) * DAYS_PER_YEAR + leaps;
    end else begin
      s1_ydays_nxt = '0;
    end
  end

  // months before the given one, february gets its extra day in leap years
  assign s1_mdays_nxt = month_days_before(in_month)
                      + MDAYS_W'(leap && (in_month >= MON_MARCH));

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_ydays_r  <= s1_ydays_nxt;
      s1_mdays_r  <= s1_mdays_nxt;
      s1_mday_r   <= in_mday;
      s1_hour_r   <= in_hour;
      s1_minute_r <= in_minute;
      s1_second_r <= in_second;
    end
  end

  // total days, wrapping to the output width when day of month is zero in january 1970 or earlier
  always_comb begin
    s2_data_nxt.days   = OUT_W'(s1_ydays_r) + OUT_W'(s1_mdays_r) + OUT_W'(s1_mday_r)
                       - OUT_W'(1);
    s2_data_nxt.hour   = s1_hour_r;
    s2_data_nxt.minute = s1_minute_r;
    s2_data_nxt.second = s1_second_r;
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_data  = s2_data_r;

`ifndef NO_ASSERTIONS
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("accepted request did not reach stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> s1_v_r && $stable(s1_ydays_r) && $stable(s1_mdays_r))
    else $error("stage 1 lost its request during a stall");

  a_dn_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn_data))
    else $error("stage 2 changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/utd_scale.sv */
// three pipeline stages that scale days to seconds through hours and minutes
`default_nettype none

module utd_scale (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire utd_pkg::utd_days_t        up_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [utd_pkg::OUT_W-1:0]      out_seconds
);
  import utd_pkg::*;

  localparam logic [OUT_W-1:0] HOURS_PER_DAY   = OUT_W'(24);
  localparam logic [OUT_W-1:0] UNITS_PER_NEXT  = OUT_W'(60);

  // hours stage
  logic              a_v_r;
  logic [OUT_W-1:0]  a_t_r;
  logic [MIN_W-1:0]  a_minute_r;
  logic [SEC_W-1:0]  a_second_r;
  // minutes stage
  logic              b_v_r;
  logic [OUT_W-1:0]  b_t_r;
  logic [SEC_W-1:0]  b_second_r;
  // seconds stage
  logic              c_v_r;
  logic [OUT_W-1:0]  c_t_r;

  logic              a_free;
  logic              b_free;
  logic              c_free;
  logic [OUT_W-1:0]  a_t_nxt;
  logic [OUT_W-1:0]  b_t_nxt;
  logic [OUT_W-1:0]  c_t_nxt;

  // ready chain from the output back
  assign c_free   = !c_v_r || out_ready;
  assign b_free   = !b_v_r || c_free;
  assign a_free   = !a_v_r || b_free;
  assign up_ready = a_free;

  // one constant multiply and add per stage, all modulo the output width
  assign a_t_nxt = up_data.days * HOURS_PER_DAY + OUT_W'(up_data.hour);
  assign b_t_nxt = a_t_r * UNITS_PER_NEXT + OUT_W'(a_minute_r);
  assign c_t_nxt = b_t_r * UNITS_PER_NEXT + OUT_W'(b_second_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= up_valid;
      end
      if (b_free) begin
        b_v_r <= a_v_r;
      end
      if (c_free) begin
        c_v_r <= b_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_free && up_valid) begin
      a_t_r      <= a_t_nxt;
      a_minute_r <= up_data.minute;
      a_second_r <= up_data.second;
    end
    if (b_free && a_v_r) begin
      b_t_r      <= b_t_nxt;
      b_second_r <= a_second_r;
    end
    if (c_free && b_v_r) begin
      c_t_r <= c_t_nxt;
    end
  end

  assign out_valid   = c_v_r;
  assign out_seconds = c_t_r;

`ifndef NO_ASSERTIONS
  a_up_to_a: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> a_v_r)
    else $error("accepted request did not reach the hours stage");

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !c_free |=> b_v_r && $stable(b_t_r) && $stable(b_second_r))
    else $error("minutes stage lost its request during a stall");

  a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && !out_ready |=> c_v_r && $stable(c_t_r))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/utc_date_to_epoch_seconds.sv */
// top level: utc broken-down date and time to seconds since 1970
//
//   channel  handshake               payload
//   in       in_valid / in_ready     year, month, day, hour, minute, second
//   out      out_valid / out_ready   out_epoch_seconds (33 bits)
//
// five register stages: year and month days, day sum, hours, minutes, seconds
// one request per cycle while the output is not stalled
// every stage holds its request while the next one is full and stalled
// reset clears only the valid bits; the pipeline is empty after reset
`default_nettype none

module utc_date_to_epoch_seconds (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [utd_pkg::YEAR_W-1:0] in_year_since_1900,
  input  wire logic [utd_pkg::MON_W-1:0]  in_month_index,
  input  wire logic [utd_pkg::MDAY_W-1:0] in_day_of_month,
  input  wire logic [utd_pkg::HOUR_W-1:0] in_hour_of_day,
  input  wire logic [utd_pkg::MIN_W-1:0]  in_minute_of_hour,
  input  wire logic [utd_pkg::SEC_W-1:0]  in_second_of_minute,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [utd_pkg::OUT_W-1:0]       out_epoch_seconds
);
  import utd_pkg::*;

  logic      dn_valid;
  logic      dn_ready;
  utd_days_t dn_data;

  // calendar half: day count since the epoch
  utd_day_count u_day_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_year   (in_year_since_1900),
    .in_month  (in_month_index),
    .in_mday   (in_day_of_month),
    .in_hour   (in_hour_of_day),
    .in_minute (in_minute_of_hour),
    .in_second (in_second_of_minute),
    .dn_valid  (dn_valid),
    .dn_ready  (dn_ready),
    .dn_data   (dn_data)
  );

  // time half: days to seconds
  utd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (dn_valid),
    .up_ready    (dn_ready),
    .up_data     (dn_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_seconds (out_epoch_seconds)
  );

endmodule

`default_nettype wire
